// ----- rtl/mcb_pkg.sv -----
// Shared types, codes and helper functions for the maze carver block.
// Used by the controller, the datapath and the top level; depends on nothing.
package mcb_pkg;

    // Width of a clamped maze dimension (holds up to 127).
    localparam int DIM_W = 7;
    // Width of a configuration register.
    localparam int CFG_W = 6;
    // Width of the reported cell coordinates.
    localparam int COORD_OUT_W = 5;

    // Input command codes.
    localparam logic CMD_STEP    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_COLS = 1'b0;
    localparam logic CFG_ROWS = 1'b1;

    // Wall directions, also the neighbor scan order.
    typedef enum logic [1:0] {
        DIR_TOP    = 2'd0,
        DIR_RIGHT  = 2'd1,
        DIR_BOTTOM = 2'd2,
        DIR_LEFT   = 2'd3
    } dir_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_NBR,
        ST_EVAL,
        ST_POP,
        ST_EMIT
    } state_t;

    // Kind of result loaded into the output register.
    typedef enum logic [1:0] {
        OK_ZERO,
        OK_CARVE,
        OK_FINISH
    } out_kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      clr_step;
        logic      take_in;
        logic      seed;
        logic      nbr_step;
        logic      eval;
        logic      pop_cap;
        logic      out_load;
        out_kind_t kind;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic nbr_last;
        logic cand_any;
        logic fill_zero;
        logic fill_one;
        logic out_free;
    } ctrl_status_t;

    // Remainder of a 15-bit value by three: base-4 digits sum to the same residue.
    function automatic logic [1:0] mod3_15(input logic [14:0] v);
        logic [15:0] w;
        logic [4:0]  s;
        logic [2:0]  t;
        logic [2:0]  u;
        w = {1'b0, v};
        s = '0;
        for (int i = 0; i < 8; i++)
        begin
            s = s + 5'(w[2*i +: 2]);
        end
        t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        u = 3'(t[1:0]) + 3'(t[2]);
        return (u >= 3'd3) ? 2'(u - 3'd3) : u[1:0];
    endfunction

    // Index among the candidates: random value modulo the candidate count.
    function automatic logic [1:0] pick_index(input logic [2:0] n,
                                              input logic [1:0] rnd_lo,
                                              input logic [1:0] rnd_mod3);
        logic [1:0] idx;
        case (n)
            3'd2:    idx = {1'b0, rnd_lo[0]};
            3'd3:    idx = rnd_mod3;
            3'd4:    idx = rnd_lo;
            default: idx = 2'd0;
        endcase
        return idx;
    endfunction

    // Direction of the idx-th set candidate bit, scanning top to left.
    function automatic logic [1:0] pick_dir(input logic [3:0] cand,
                                            input logic [1:0] idx);
        logic [1:0] cnt;
        logic [1:0] dir;
        logic       found;
        cnt   = 2'd0;
        dir   = 2'd0;
        found = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            if (cand[i])
            begin
                if (!found && cnt == idx)
                begin
                    dir   = 2'(i);
                    found = 1'b1;
                end
                cnt = cnt + 2'd1;
            end
        end
        return dir;
    endfunction

endpackage

// ----- rtl/mcb_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Self-contained; used for the visited map and the path stack.
module mcb_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/mcb_ctrl.sv -----
// Sequencing state machine of the maze carver: clearing pass, neighbor scan,
// evaluation, backtracking pops and result hand-off. Depends on mcb_pkg.
module mcb_ctrl import mcb_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic         cmd,
    input  ctrl_status_t sts,
    output ctrl_cmd_t    ctl
);

    state_t    state_reg, state_next;
    out_kind_t kind_reg, kind_next;
    logic      pend_reg, pend_next;

    // State registers; reset starts with a clearing pass over the visited map.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            kind_reg  <= OK_ZERO;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            pend_reg  <= pend_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        pend_next  = pend_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    pend_next = 1'b0;
                    if (pend_reg)
                    begin
                        kind_next  = OK_ZERO;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (cmd == CMD_RESTART)
                    begin
                        pend_next  = 1'b1;
                        state_next = ST_CLEAR;
                    end
                    else if (sts.fill_zero)
                    begin
                        kind_next  = OK_FINISH;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_NBR;
                    end
                end
            end
            ST_NBR:
            begin
                if (sts.nbr_last)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (sts.cand_any)
                begin
                    kind_next  = OK_CARVE;
                    state_next = ST_EMIT;
                end
                else if (sts.fill_one)
                begin
                    kind_next  = OK_FINISH;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_POP;
                end
            end
            ST_POP:
            begin
                state_next = ST_NBR;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        in_stall = 1'b1;
        ctl      = '0;
        ctl.kind = kind_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                ctl.clr_step = 1'b1;
            end
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                ctl.take_in = in_valid;
                ctl.seed    = in_valid && (cmd == CMD_RESTART);
            end
            ST_NBR:
            begin
                ctl.nbr_step = 1'b1;
            end
            ST_EVAL:
            begin
                ctl.eval = 1'b1;
            end
            ST_POP:
            begin
                ctl.pop_cap = 1'b1;
            end
            ST_EMIT:
            begin
                ctl.out_load = sts.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // A restart result is only produced after the clearing pass it started.
    a_pend_from_restart: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pend_reg) |-> $past(ctl.seed))
        else $error("restart pending flag set without a restart transfer");

    // Every pop capture follows an evaluation that found no candidate.
    a_pop_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pop_cap |-> ($past(ctl.eval) && !$past(sts.cand_any)))
        else $error("stack pop without a failed evaluation");

    // No result is loaded outside the hand-off state.
    a_load_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> (state_reg == ST_EMIT) && !ctl.take_in)
        else $error("result load outside hand-off");

endmodule

// ----- rtl/mcb_dpath.sv -----
// Datapath of the maze carver: current cell, stack fill, neighbor candidates,
// visited map and path stack memories, and the output register.
// Depends on mcb_pkg and mcb_ram.
module mcb_dpath import mcb_pkg::*; #(
    parameter int MAX_COLS = 32,
    parameter int MAX_ROWS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [DIM_W-1:0]       cols,
    input  logic [DIM_W-1:0]       rows,
    input  logic [14:0]            random_value,
    input  ctrl_cmd_t              ctl,
    output ctrl_status_t           sts,
    input  logic                   out_stall,
    output logic                   out_valid,
    output logic                   carved,
    output logic [COORD_OUT_W-1:0] from_x,
    output logic [COORD_OUT_W-1:0] from_y,
    output logic [1:0]             carve_dir,
    output logic                   finished
);

    localparam int XW         = $clog2(MAX_COLS);
    localparam int YW         = $clog2(MAX_ROWS);
    localparam int CW         = XW + YW;
    localparam int VDEPTH     = 1 << CW;
    localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;
    localparam int SAW        = $clog2(CELL_COUNT);
    localparam int FW         = $clog2(CELL_COUNT + 1);

    // Control registers.
    logic [XW-1:0] cur_x_reg, cur_x_next;
    logic [YW-1:0] cur_y_reg, cur_y_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [2:0]    nbr_cnt_reg, nbr_cnt_next;
    logic [CW-1:0] clr_cnt_reg, clr_cnt_next;
    logic          out_valid_reg, out_valid_next;

    // Payload registers.
    logic [1:0]             rnd_lo_reg, rnd_lo_next;
    logic [1:0]             rnd_m3_reg, rnd_m3_next;
    logic [3:0]             cand_reg, cand_next;
    logic [XW-1:0]          res_x_reg, res_x_next;
    logic [YW-1:0]          res_y_reg, res_y_next;
    logic [1:0]             res_dir_reg, res_dir_next;
    logic                   carved_reg, carved_next;
    logic [COORD_OUT_W-1:0] from_x_reg, from_x_next;
    logic [COORD_OUT_W-1:0] from_y_reg, from_y_next;
    logic [1:0]             dir_reg, dir_next;
    logic                   finished_reg, finished_next;

    // Neighbor coordinates and bounds of the current cell.
    logic [XW-1:0] nb_x [4];
    logic [YW-1:0] nb_y [4];
    logic [3:0]    nb_in;

    logic [1:0]    scan_dir;
    logic [1:0]    cap_dir;
    logic [2:0]    cand_n;
    logic [1:0]    pick_idx;
    logic [1:0]    pick_d;
    logic          stack_full;

    // Memory ports.
    logic          vis_we;
    logic [CW-1:0] vis_waddr;
    logic          vis_wdata;
    logic [CW-1:0] vis_raddr;
    logic          vis_rdata;
    logic          stk_we;
    logic [SAW-1:0] stk_waddr;
    logic [CW-1:0] stk_wdata;
    logic [SAW-1:0] stk_raddr;
    logic [CW-1:0] stk_rdata;

    // Neighbors in the order top, right, bottom, left.
    always_comb
    begin
        nb_x[DIR_TOP]     = cur_x_reg;
        nb_y[DIR_TOP]     = cur_y_reg - YW'(1);
        nb_in[DIR_TOP]    = (cur_y_reg != '0);
        nb_x[DIR_RIGHT]   = cur_x_reg + XW'(1);
        nb_y[DIR_RIGHT]   = cur_y_reg;
        nb_in[DIR_RIGHT]  = (DIM_W'(cur_x_reg) + DIM_W'(1)) < cols;
        nb_x[DIR_BOTTOM]  = cur_x_reg;
        nb_y[DIR_BOTTOM]  = cur_y_reg + YW'(1);
        nb_in[DIR_BOTTOM] = (DIM_W'(cur_y_reg) + DIM_W'(1)) < rows;
        nb_x[DIR_LEFT]    = cur_x_reg - XW'(1);
        nb_y[DIR_LEFT]    = cur_y_reg;
        nb_in[DIR_LEFT]   = (cur_x_reg != '0);
    end

    // Candidate selection.
    assign scan_dir   = nbr_cnt_reg[1:0];
    assign cap_dir    = 2'(nbr_cnt_reg - 3'd1);
    assign cand_n     = 3'($countones(cand_reg));
    assign pick_idx   = pick_index(cand_n, rnd_lo_reg, rnd_m3_reg);
    assign pick_d     = pick_dir(cand_reg, pick_idx);
    assign stack_full = (fill_reg == FW'(CELL_COUNT));

    // Visited map: swept on clear (cell zero set), set on a carve.
    assign vis_we    = ctl.clr_step || (ctl.eval && (cand_reg != '0));
    assign vis_waddr = ctl.clr_step ? clr_cnt_reg : {nb_y[pick_d], nb_x[pick_d]};
    assign vis_wdata = ctl.clr_step ? (clr_cnt_reg == '0) : 1'b1;
    assign vis_raddr = {nb_y[scan_dir], nb_x[scan_dir]};

    // Path stack: entry zero holds cell zero, a carve pushes the new cell.
    assign stk_we    = (ctl.clr_step && (clr_cnt_reg == '0))
                    || (ctl.eval && (cand_reg != '0) && !stack_full);
    assign stk_waddr = ctl.clr_step ? '0 : fill_reg[SAW-1:0];
    assign stk_wdata = ctl.clr_step ? '0 : {nb_y[pick_d], nb_x[pick_d]};
    assign stk_raddr = SAW'(fill_reg - FW'(2));

    mcb_ram #(
        .WIDTH (1),
        .DEPTH (VDEPTH)
    ) u_visited (
        .clk   (clk),
        .we    (vis_we),
        .waddr (vis_waddr),
        .wdata (vis_wdata),
        .raddr (vis_raddr),
        .rdata (vis_rdata)
    );

    mcb_ram #(
        .WIDTH (CW),
        .DEPTH (CELL_COUNT)
    ) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // Register updates commanded by the controller.
    always_comb
    begin
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        fill_next      = fill_reg;
        nbr_cnt_next   = nbr_cnt_reg;
        clr_cnt_next   = clr_cnt_reg;
        rnd_lo_next    = rnd_lo_reg;
        rnd_m3_next    = rnd_m3_reg;
        cand_next      = cand_reg;
        res_x_next     = res_x_reg;
        res_y_next     = res_y_reg;
        res_dir_next   = res_dir_reg;
        carved_next    = carved_reg;
        from_x_next    = from_x_reg;
        from_y_next    = from_y_reg;
        dir_next       = dir_reg;
        finished_next  = finished_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (ctl.clr_step)
        begin
            clr_cnt_next = clr_cnt_reg + CW'(1);
        end

        // Capture the random value; a restart reseeds cell zero.
        if (ctl.take_in)
        begin
            rnd_lo_next = random_value[1:0];
            rnd_m3_next = mod3_15(random_value);
        end
        if (ctl.seed)
        begin
            cur_x_next = '0;
            cur_y_next = '0;
            fill_next  = FW'(1);
        end

        // One visited read issued per cycle, captured in the next cycle.
        if (ctl.nbr_step)
        begin
            if (nbr_cnt_reg != 3'd0)
            begin
                cand_next[cap_dir] = nb_in[cap_dir] && !vis_rdata;
            end
            nbr_cnt_next = (nbr_cnt_reg == 3'd4) ? 3'd0 : nbr_cnt_reg + 3'd1;
        end

        // Carve toward the picked neighbor or pop the current cell.
        if (ctl.eval)
        begin
            if (cand_reg != '0)
            begin
                res_x_next   = cur_x_reg;
                res_y_next   = cur_y_reg;
                res_dir_next = pick_d;
                if (!stack_full)
                begin
                    fill_next  = fill_reg + FW'(1);
                    cur_x_next = nb_x[pick_d];
                    cur_y_next = nb_y[pick_d];
                end
            end
            else
            begin
                fill_next = fill_reg - FW'(1);
            end
        end

        // New top of stack after a pop.
        if (ctl.pop_cap)
        begin
            cur_x_next = stk_rdata[XW-1:0];
            cur_y_next = stk_rdata[CW-1:XW];
        end

        // Output register load.
        if (ctl.out_load)
        begin
            out_valid_next = 1'b1;
            carved_next    = 1'b0;
            from_x_next    = '0;
            from_y_next    = '0;
            dir_next       = 2'd0;
            finished_next  = 1'b0;
            case (ctl.kind)
                OK_CARVE:
                begin
                    carved_next = 1'b1;
                    from_x_next = COORD_OUT_W'(res_x_reg);
                    from_y_next = COORD_OUT_W'(res_y_reg);
                    dir_next    = res_dir_reg;
                end
                OK_FINISH:
                begin
                    finished_next = 1'b1;
                end
                default:
                begin
                    finished_next = 1'b0;
                end
            endcase
        end
    end

    // Control state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            fill_reg      <= FW'(1);
            nbr_cnt_reg   <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            fill_reg      <= fill_next;
            nbr_cnt_reg   <= nbr_cnt_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        rnd_lo_reg   <= rnd_lo_next;
        rnd_m3_reg   <= rnd_m3_next;
        cand_reg     <= cand_next;
        res_x_reg    <= res_x_next;
        res_y_reg    <= res_y_next;
        res_dir_reg  <= res_dir_next;
        carved_reg   <= carved_next;
        from_x_reg   <= from_x_next;
        from_y_reg   <= from_y_next;
        dir_reg      <= dir_next;
        finished_reg <= finished_next;
    end

    // Status to the controller.
    always_comb
    begin
        sts.clr_last  = (clr_cnt_reg == '1);
        sts.nbr_last  = (nbr_cnt_reg == 3'd4);
        sts.cand_any  = (cand_reg != '0);
        sts.fill_zero = (fill_reg == '0);
        sts.fill_one  = (fill_reg == FW'(1));
        sts.out_free  = !out_valid_reg || !out_stall;
    end

    assign out_valid = out_valid_reg;
    assign carved    = carved_reg;
    assign from_x    = from_x_reg;
    assign from_y    = from_y_reg;
    assign carve_dir = dir_reg;
    assign finished  = finished_reg;

    // The stack fill never passes the cell count.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(CELL_COUNT))
        else $error("stack fill beyond cell count");

    // A carve into a non-full stack grows the fill by exactly one.
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.eval && (cand_reg != '0) && !stack_full)
        |=> fill_reg == $past(fill_reg) + FW'(1))
        else $error("carve did not push the new cell");

    // A result without a carve has zero cell and direction fields.
    a_no_carve_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !carved_reg)
        |-> (from_x_reg == '0) && (from_y_reg == '0) && (dir_reg == 2'd0))
        else $error("non-carve result with stray fields");

    // Carved and finished are never reported together.
    a_carve_xor_fin: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(carved_reg && finished_reg))
        else $error("result both carved and finished");

endmodule

// ----- rtl/maze_carver_backtracker.sv -----
// Top level of the recursive-backtracker maze carver: configuration registers,
// dimension clamping, controller and datapath. Depends on mcb_pkg, mcb_ctrl, mcb_dpath.
//
//   Channel   Direction  Handshake             Payload
//   in        input      in_valid / in_stall   cmd, random_value
//   out       output     out_valid / out_stall carved, from_x, from_y, carve_dir, finished
//   cfg       input      cfg_we                cfg_index, cfg_data
//
// A carve step with no backtracking runs from the transfer through a neighbor scan and an
// evaluation to the result; the scan reads the four neighbors through the single read port.
// Each cell popped while backtracking adds an evaluation, a stack read and a rescan.
// Reset and every restart sweep the visited map, one entry a cycle, over all
// 2**(clog2(MAX_COLS)+clog2(MAX_ROWS)) entries, 1024 at the defaults; no input is taken then.
// One item is in work at a time. Its result moves into the output register once that
// register is free; a result there holds while out_stall is high, and the next input
// transfer can follow the load, before the previous result is handed off.
module maze_carver_backtracker import mcb_pkg::*; #(
    parameter int MAX_COLS = 32,
    parameter int MAX_ROWS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   cmd,
    input  logic [14:0]            random_value,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   carved,
    output logic [COORD_OUT_W-1:0] from_x,
    output logic [COORD_OUT_W-1:0] from_y,
    output logic [1:0]             carve_dir,
    output logic                   finished,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    logic [CFG_W-1:0] cols_reg, cols_next;
    logic [CFG_W-1:0] rows_reg, rows_next;
    logic [DIM_W-1:0] cols_eff;
    logic [DIM_W-1:0] rows_eff;
    ctrl_cmd_t        ctl;
    ctrl_status_t     sts;

    // Configuration writes.
    always_comb
    begin
        cols_next = cols_reg;
        rows_next = rows_reg;
        if (cfg_we)
        begin
            if (cfg_index == CFG_COLS)
            begin
                cols_next = cfg_data;
            end
            else
            begin
                rows_next = cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= CFG_W'(25);
            rows_reg <= CFG_W'(20);
        end
        else
        begin
            cols_reg <= cols_next;
            rows_reg <= rows_next;
        end
    end

    // Clamp the dimensions into two up to the maximum.
    always_comb
    begin
        if (DIM_W'(cols_reg) < DIM_W'(2))
        begin
            cols_eff = DIM_W'(2);
        end
        else if (DIM_W'(cols_reg) > DIM_W'(MAX_COLS))
        begin
            cols_eff = DIM_W'(MAX_COLS);
        end
        else
        begin
            cols_eff = DIM_W'(cols_reg);
        end

        if (DIM_W'(rows_reg) < DIM_W'(2))
        begin
            rows_eff = DIM_W'(2);
        end
        else if (DIM_W'(rows_reg) > DIM_W'(MAX_ROWS))
        begin
            rows_eff = DIM_W'(MAX_ROWS);
        end
        else
        begin
            rows_eff = DIM_W'(rows_reg);
        end
    end

    mcb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .sts      (sts),
        .ctl      (ctl)
    );

    mcb_dpath #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cols         (cols_eff),
        .rows         (rows_eff),
        .random_value (random_value),
        .ctl          (ctl),
        .sts          (sts),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .carved       (carved),
        .from_x       (from_x),
        .from_y       (from_y),
        .carve_dir    (carve_dir),
        .finished     (finished)
    );

endmodule
